// ===== rtl/task_table_round_robin_scheduler_macros.svh =====
// assertion macros for the task scheduler
`ifndef TASK_TABLE_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define TASK_TABLE_ROUND_ROBIN_SCHEDULER_MACROS_SVH
// a condition implies a consequence in the same cycle
`define TTRR_ASSERT_IMP(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("assertion failed");
// a condition implies a consequence in the next cycle
`define TTRR_ASSERT_NEXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/ttrr_pkg.sv =====
package ttrr_pkg;
  localparam int unsigned TableSlotsDefault = 16;
  localparam int unsigned PidW = 16;

  localparam logic [2:0] ReqCreate    = 3'd0;
  localparam logic [2:0] ReqExit      = 3'd1;
  localparam logic [2:0] ReqTerminate = 3'd2;
  localparam logic [2:0] ReqYield     = 3'd3;
  localparam logic [2:0] ReqWait      = 3'd4;
  localparam logic [2:0] ReqQuery     = 3'd5;

  localparam logic [1:0] LcReady      = 2'd0;
  localparam logic [1:0] LcRunning    = 2'd1;
  localparam logic [1:0] LcTerminated = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StError  = 2'd1;
  localparam logic [1:0] StNoChild = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_ACT, S_DISP_SCAN, S_DISP_APPLY, S_OUT
  } fsm_e;

  typedef enum logic [2:0] {
    SCAN_TERM, SCAN_PID, SCAN_CHILD, SCAN_READY
  } scan_e;

  // controller to datapath
  typedef struct packed {
    logic  load;        // capture request word
    logic  scan_start;  // clear scan pointer and flags
    logic  scan_step;   // examine one slot
    scan_e scan_kind;
    logic  act;         // apply the request
    logic  disp_start;
    logic  disp_apply;
    logic  out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       scan_done;
    logic       need_disp;
    logic [2:0] req;
  } sts_t;
endpackage

// ===== rtl/ttrr_datapath.sv =====
module ttrr_datapath #(
  parameter int unsigned TableSlots = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ttrr_pkg::cmd_t  cmd_i,
  output ttrr_pkg::sts_t  sts_o,
  input  logic [35:0]     req_word_i,
  output logic [56:0]     res_word_o
);
  import ttrr_pkg::*;
  localparam int unsigned IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned CntW = $clog2(TableSlots + 1);

  // slot table in flip-flops with per-slot reset values
  logic [PidW-1:0] pid_q [TableSlots];
  logic [PidW-1:0] par_q [TableSlots];
  logic [1:0]      lc_q  [TableSlots];
  logic [7:0]      code_q [TableSlots];
  logic [7:0]      sig_q  [TableSlots];
  logic [CntW-1:0] used_q;
  logic [PidW-1:0] pidc_q;
  logic [IdxW-1:0] cur_q;

  // request word
  logic [2:0]  req_q;
  logic [16:0] tgt_q;
  logic [7:0]  code_in_q, sig_in_q;

  // scan state
  logic [CntW-1:0] ptr_q;
  logic            hit_q, child_q, idle_q;
  logic [IdxW-1:0] hit_idx_q;
  scan_e           kind_q;
  logic            swd_q, need_q;
  logic [1:0]      status_q, qst_q;
  logic [PidW-1:0] rpid_q, wst_q;

  logic [IdxW-1:0] pi, cur_next;
  logic [CntW:0]   ring;
  logic            cand;
  logic            tneg, tpos;
  logic [PidW-1:0] me;

  assign tneg = tgt_q[16];
  assign tpos = !tgt_q[16] && (tgt_q[15:0] != '0);
  assign me   = pid_q[cur_q];

  // ring index for dispatch scan, plain index otherwise
  always_comb begin
    ring = {1'b0, ptr_q} + {{(CntW+1-IdxW){1'b0}}, cur_q} + 1'b1;
    if (ring >= {1'b0, used_q}) ring = ring - {1'b0, used_q};
    if (kind_q == SCAN_READY) pi = ring[IdxW-1:0];
    else pi = ptr_q[IdxW-1:0];
    cand = 1'b0;
    case (kind_q)
      SCAN_TERM:  cand = lc_q[pi] == LcTerminated;
      SCAN_PID:   cand = !tneg && pid_q[pi] == tgt_q[15:0];
      SCAN_CHILD: cand = (pi != '0) && pid_q[pi] != '0 && par_q[pi] == me &&
                         (!tpos || tgt_q[15:0] == pid_q[pi]);
      SCAN_READY: cand = lc_q[pi] == LcReady && pi != '0;
      default:    cand = 1'b0;
    endcase
  end

  assign sts_o.scan_done = hit_q || (ptr_q >= used_q);
  assign sts_o.need_disp = need_q;
  assign sts_o.req       = req_q;
  assign cur_next        = cur_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= req_word_i[2:0];
      tgt_q     <= req_word_i[19:3];
      code_in_q <= req_word_i[27:20];
      sig_in_q  <= req_word_i[35:28];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableSlots; i++) begin
        pid_q[i]  <= (i == 0) ? PidW'(1) : (i == 1) ? PidW'(2) : '0;
        par_q[i]  <= '0;
        lc_q[i]   <= (i == 1) ? LcRunning : LcReady;
        code_q[i] <= '0;
        sig_q[i]  <= '0;
      end
      used_q <= CntW'(2);
      pidc_q <= PidW'(3);
      cur_q  <= IdxW'(1);
      ptr_q <= '0; hit_q <= 1'b0; child_q <= 1'b0; idle_q <= 1'b0;
      hit_idx_q <= '0; kind_q <= SCAN_TERM; swd_q <= 1'b0; need_q <= 1'b0;
      status_q <= StOk; qst_q <= '0; rpid_q <= '0; wst_q <= '0;
      res_word_o <= '0;
    end else begin
      if (cmd_i.scan_start || cmd_i.disp_start) begin
        ptr_q <= '0; hit_q <= 1'b0; child_q <= 1'b0; idle_q <= 1'b0;
        kind_q <= cmd_i.disp_start ? SCAN_READY : cmd_i.scan_kind;
        if (cmd_i.scan_start) begin
          swd_q <= 1'b0; need_q <= 1'b0; status_q <= StOk;
          qst_q <= '0; rpid_q <= '0; wst_q <= '0;
        end
      end else if (cmd_i.scan_step && !(hit_q || ptr_q >= used_q)) begin
        ptr_q <= ptr_q + 1'b1;
        if (kind_q == SCAN_READY && pi == '0 && lc_q[pi] == LcReady)
          idle_q <= 1'b1;
        if (kind_q == SCAN_CHILD && cand) begin
          child_q <= 1'b1;
          if (lc_q[pi] == LcTerminated) begin
            hit_q <= 1'b1; hit_idx_q <= pi;
          end
        end else if (cand) begin
          hit_q <= 1'b1; hit_idx_q <= pi;
        end
      end
      // apply request
      if (cmd_i.act) begin
        case (req_q)
          ReqCreate: begin
            if (!hit_q && used_q >= CntW'(TableSlots)) status_q <= StError;
            else begin
              logic [IdxW-1:0] s;
              s = hit_q ? hit_idx_q : used_q[IdxW-1:0];
              if (!hit_q) used_q <= used_q + 1'b1;
              pid_q[s] <= pidc_q;
              pidc_q <= pidc_q + 1'b1;
              par_q[s] <= (s == cur_q) ? pidc_q : me;
              lc_q[s] <= LcReady;
              code_q[s] <= '0; sig_q[s] <= '0;
              rpid_q <= pidc_q;
            end
          end
          ReqExit: begin
            lc_q[cur_q] <= LcTerminated; need_q <= 1'b1;
          end
          ReqTerminate: begin
            if (!hit_q || hit_idx_q == '0) status_q <= StError;
            else if (lc_q[hit_idx_q] != LcTerminated) begin
              code_q[hit_idx_q] <= code_in_q;
              sig_q[hit_idx_q]  <= sig_in_q;
              lc_q[hit_idx_q]   <= LcTerminated;
              need_q <= hit_idx_q == cur_q;
            end
          end
          ReqYield: need_q <= 1'b1;
          ReqWait: begin
            if (hit_q) begin
              rpid_q <= pid_q[hit_idx_q];
              wst_q  <= (sig_q[hit_idx_q] != '0) ?
                        {9'd0, sig_q[hit_idx_q][6:0]} : {code_q[hit_idx_q], 8'd0};
              pid_q[hit_idx_q] <= '0; par_q[hit_idx_q] <= '0;
              code_q[hit_idx_q] <= '0; sig_q[hit_idx_q] <= '0;
            end else status_q <= child_q ? StNoChild : StError;
          end
          ReqQuery: begin
            if (hit_q) qst_q <= lc_q[hit_idx_q];
            else status_q <= StError;
          end
          default: status_q <= StError;
        endcase
      end
      // dispatch commit
      if (cmd_i.disp_apply) begin
        if (hit_q || idle_q) begin
          logic [IdxW-1:0] p;
          p = hit_q ? hit_idx_q : '0;
          swd_q <= 1'b1;
          cur_q <= p;
          lc_q[p] <= LcRunning;
          if (cur_q != p && lc_q[cur_q] == LcRunning) lc_q[cur_q] <= LcReady;
        end
      end
      if (cmd_i.out_load)
        res_word_o <= {pid_q[cur_next], 4'(cur_next), swd_q, qst_q, wst_q,
                       rpid_q, status_q};
    end
  end
endmodule

// ===== rtl/ttrr_ctrl.sv =====
module ttrr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ttrr_pkg::cmd_t cmd_o,
  input  ttrr_pkg::sts_t sts_i
);
  import ttrr_pkg::*;
  `include "task_table_round_robin_scheduler_macros.svh"
  fsm_e state_q, state_d;
  logic ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign in_ready_o  = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    cmd_o.scan_kind = SCAN_TERM;
    case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        cmd_o.load = 1'b1; state_d = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.scan_start = 1'b1;
        case (sts_i.req)
          ReqCreate: cmd_o.scan_kind = SCAN_TERM;
          ReqTerminate, ReqQuery: cmd_o.scan_kind = SCAN_PID;
          ReqWait: cmd_o.scan_kind = SCAN_CHILD;
          default: cmd_o.scan_kind = SCAN_TERM;
        endcase
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done || sts_i.req == ReqExit || sts_i.req == ReqYield)
          state_d = S_ACT;
      end
      S_ACT: begin
        cmd_o.act = 1'b1; state_d = S_DISP_SCAN;
      end
      S_DISP_SCAN: begin
        if (sts_i.need_disp) begin
          cmd_o.disp_start = 1'b1; state_d = S_DISP_APPLY;
        end else state_d = S_OUT;
      end
      S_DISP_APPLY: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.disp_apply = 1'b1; state_d = S_OUT;
        end
      end
      // wait here while the previous word is still held
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `TTRR_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == S_IDLE)
  `TTRR_ASSERT_NEXT(a_out_after, clk_i, rst_ni, state_q == S_OUT, out_valid_o)
  `TTRR_ASSERT_NEXT(a_load_decode, clk_i, rst_ni, cmd_o.load, state_q == S_DECODE)
endmodule

// ===== rtl/task_table_round_robin_scheduler.sv =====
// channel | fields (low bit up)                                    | width
// s_axis  | req_type, target_pid, exit_code, signal_number, no_hang| 40
// m_axis  | status, result_pid, wait_status, queried_state,        | 64
//         | switched, running_slot, running_pid                    |
// one request in flight; the slot scan visits one slot per cycle
// a dispatch adds a ring scan over the used slots
// reset loads slots 0 and 1 and clears the others; the table is in flip-flops, no clearing pass
// a held result stalls only the last step of the next request until taken
module task_table_round_robin_scheduler #(
  parameter int unsigned TableSlots = ttrr_pkg::TableSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // req_type, target_pid, exit_code, signal_number, no_hang
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // status, result_pid, wait_status, queried_state,
                                     // switched, running_slot, running_pid
);
  import ttrr_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic [56:0] res;

  ttrr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts)
  );

  ttrr_datapath #(.TableSlots(TableSlots)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_word_i(s_axis_tdata[35:0]), .res_word_o(res)
  );

  assign m_axis_tdata = {7'd0, res};
endmodule

// ===== test/task_table_round_robin_scheduler_tb.sv =====
`timescale 1ns / 1ps

module task_table_round_robin_scheduler_tb;
  import ttrr_pkg::*;

  localparam int unsigned Slots = 16;

  typedef struct packed {
    logic        no_hang;
    logic [7:0]  signal_number;
    logic [7:0]  exit_code;
    logic [16:0] target_pid;
    logic [2:0]  req_type;
  } req_word_t;

  typedef struct packed {
    logic [15:0] running_pid;
    logic [3:0]  running_slot;
    logic        switched;
    logic [1:0]  queried_state;
    logic [15:0] wait_status;
    logic [15:0] result_pid;
    logic [1:0]  status;
  } rsp_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  task_table_round_robin_scheduler dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),  // req_type, target_pid, exit_code, signal_number, no_hang
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)   // status, result_pid, wait_status, queried_state,
                                  // switched, running_slot, running_pid
  );

  // shadow task table
  logic [15:0] tt_pid[Slots];
  logic [15:0] tt_parent[Slots];
  logic [1:0]  tt_life[Slots];
  logic [7:0]  tt_code[Slots];
  logic [7:0]  tt_sig[Slots];
  int unsigned tt_used;
  logic [15:0] tt_next_pid;
  int unsigned tt_cur;

  req_word_t   pending_reqs[$];
  rsp_word_t   expected_rsps[$];
  int          errors;
  int          reqs_sent;
  int          rsps_seen;
  int          switches_seen;
  int          reaps_seen;
  bit          calm;
  bit          stim_done;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // limit
  initial begin
    #20ms;
    $display("timeout");
    $display("** task_table_round_robin_scheduler: FAILED **");
    $finish;
  end

  task automatic table_reset();
    for (int i = 0; i < Slots; i++) begin
      tt_pid[i] = '0;
      tt_parent[i] = '0;
      tt_life[i] = LcReady;
      tt_code[i] = '0;
      tt_sig[i] = '0;
    end
    tt_pid[0] = 16'd1;
    tt_pid[1] = 16'd2;
    tt_life[1] = LcRunning;
    tt_used = 2;
    tt_next_pid = 16'd3;
    tt_cur = 1;
  endtask

  // round-robin pick; idle slot only as last resort
  function automatic bit dispatch_next();
    int unsigned pick;
    int unsigned idx;
    bit found;
    bit idle_ok;
    int unsigned prev;
    found = 0;
    idle_ok = 0;
    pick = 0;
    prev = tt_cur;
    for (int unsigned k = 1; k <= tt_used; k++) begin
      idx = (prev + k) % tt_used;
      if (!found && tt_life[idx] == LcReady) begin
        if (idx == 0) idle_ok = 1;
        else begin
          pick = idx;
          found = 1;
        end
      end
    end
    if (!found && idle_ok) begin
      pick = 0;
      found = 1;
    end
    if (!found) return 0;
    tt_cur = pick;
    tt_life[pick] = LcRunning;
    if (prev != pick && tt_life[prev] == LcRunning) tt_life[prev] = LcReady;
    return 1;
  endfunction

  function automatic bit lookup_pid(int target, output int unsigned where);
    where = 0;
    if (target < 0) return 0;
    for (int unsigned i = 0; i < tt_used; i++)
      if (tt_pid[i] == target[15:0] && target < 65536) begin
        where = i;
        return 1;
      end
    return 0;
  endfunction

  function automatic rsp_word_t apply_request(req_word_t r);
    rsp_word_t o;
    int target;
    int unsigned s;
    bit have;
    bit kid_seen;
    bit reaped;
    logic [15:0] me;
    o = '0;
    target = $signed(r.target_pid);
    case (r.req_type)
      ReqCreate: begin
        have = 0;
        for (int unsigned i = 0; i < tt_used; i++)
          if (!have && tt_life[i] == LcTerminated) begin
            s = i;
            have = 1;
          end
        if (!have && tt_used >= Slots) o.status = StError;
        else begin
          if (!have) begin
            s = tt_used;
            tt_used++;
          end
          tt_pid[s] = tt_next_pid;
          tt_next_pid = tt_next_pid + 16'd1;
          tt_parent[s] = tt_pid[tt_cur];
          tt_life[s] = LcReady;
          tt_code[s] = '0;
          tt_sig[s] = '0;
          o.result_pid = tt_pid[s];
        end
      end
      ReqExit: begin
        tt_life[tt_cur] = LcTerminated;
        o.switched = dispatch_next();
      end
      ReqTerminate: begin
        if (!lookup_pid(target, s) || s == 0) o.status = StError;
        else if (tt_life[s] != LcTerminated) begin
          tt_code[s] = r.exit_code;
          tt_sig[s] = r.signal_number;
          tt_life[s] = LcTerminated;
          if (s == tt_cur) o.switched = dispatch_next();
        end
      end
      ReqYield: o.switched = dispatch_next();
      ReqWait: begin
        kid_seen = 0;
        reaped = 0;
        me = tt_pid[tt_cur];
        for (int unsigned i = 1; i < tt_used; i++) begin
          if (!reaped && tt_pid[i] != 0 && tt_parent[i] == me &&
              !(target > 0 && target[15:0] != tt_pid[i])) begin
            kid_seen = 1;
            if (tt_life[i] == LcTerminated) begin
              o.result_pid = tt_pid[i];
              o.wait_status = (tt_sig[i] != 0) ? {9'd0, tt_sig[i][6:0]}
                                               : {tt_code[i], 8'd0};
              tt_pid[i] = '0;
              tt_parent[i] = '0;
              tt_code[i] = '0;
              tt_sig[i] = '0;
              reaped = 1;
            end
          end
        end
        if (!reaped) o.status = kid_seen ? StNoChild : StError;
      end
      ReqQuery: begin
        if (lookup_pid(target, s)) o.queried_state = tt_life[s];
        else o.status = StError;
      end
      default: o.status = StError;
    endcase
    o.running_slot = tt_cur[3:0];
    o.running_pid = tt_pid[tt_cur];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch on response %0d: %s got %0h want %0h", rsps_seen, what, got, want);
  endtask

  // random pid biased toward live ones
  function automatic logic [16:0] pick_pid();
    int unsigned c;
    c = $urandom_range(0, 9);
    if (c < 6) return {1'b0, tt_pid[$urandom_range(0, tt_used - 1)]};
    if (c == 6) return 17'h1ffff;
    if (c == 7) return 17'd0;
    if (c == 8) return {1'b1, 16'($urandom)};
    return {1'b0, 16'($urandom)};
  endfunction

  function automatic req_word_t make_req(logic [2:0] kind, logic [16:0] pid);
    req_word_t r;
    r.req_type = kind;
    r.target_pid = pid;
    r.exit_code = 8'($urandom);
    r.signal_number = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom);
    r.no_hang = 1'($urandom);
    return r;
  endfunction

  // stimulus; predictions are made at acceptance, so a shadow copy here only steers
  initial begin
    req_word_t r;
    int unsigned roll;
    errors = 0;
    reqs_sent = 0;
    rsps_seen = 0;
    switches_seen = 0;
    reaps_seen = 0;
    stim_done = 0;
    calm = 0;
    table_reset();
    // directed
    pending_reqs.push_back(make_req(ReqQuery, 17'd1));
    pending_reqs.push_back(make_req(ReqQuery, 17'd2));
    pending_reqs.push_back(make_req(ReqQuery, 17'h1ffff));
    pending_reqs.push_back(make_req(ReqTerminate, 17'd1));
    pending_reqs.push_back(make_req(ReqTerminate, 17'd999));
    pending_reqs.push_back(make_req(ReqWait, 17'd0));
    for (int i = 0; i < 15; i++) pending_reqs.push_back(make_req(ReqCreate, 17'd0));
    pending_reqs.push_back(make_req(ReqYield, 17'd0));
    r = make_req(ReqTerminate, 17'd3);
    r.signal_number = 8'hff;
    pending_reqs.push_back(r);
    r = make_req(ReqTerminate, 17'd4);
    r.signal_number = 8'd0;
    r.exit_code = 8'hff;
    pending_reqs.push_back(r);
    pending_reqs.push_back(make_req(ReqTerminate, 17'd4));
    pending_reqs.push_back(make_req(3'd6, 17'd0));
    pending_reqs.push_back(make_req(3'd7, 17'hffff));
    pending_reqs.push_back(make_req(ReqExit, 17'd0));
    pending_reqs.push_back(make_req(ReqWait, 17'h1ffff));
    // random
    for (int n = 0; n < 450; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) r = make_req(ReqCreate, pick_pid());
      else if (roll < 30) r = make_req(ReqExit, pick_pid());
      else if (roll < 48) r = make_req(ReqTerminate, pick_pid());
      else if (roll < 65) r = make_req(ReqYield, pick_pid());
      else if (roll < 85) r = make_req(ReqWait, pick_pid());
      else if (roll < 96) r = make_req(ReqQuery, pick_pid());
      else r = make_req(3'($urandom_range(6, 7)), pick_pid());
      r.target_pid[16] = r.target_pid[16] | (roll == 97);
      pending_reqs.push_back(r);
    end
    stim_done = 1;
  end

  // reset and quiet window
  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (200) @(posedge clk_i);
    calm <= 1'b1;
    repeat (3000) @(posedge clk_i);
    calm <= 1'b0;
  end

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      m_axis_tready <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsps.push_back(apply_request(req_word_t'(s_axis_tdata[36:0])));
        reqs_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {3'd0, pending_reqs.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    rsp_word_t got;
    rsp_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = rsp_word_t'(m_axis_tdata[56:0]);
      if (expected_rsps.size() == 0) begin
        errors++;
        $display("response %0d arrived with none expected", rsps_seen);
      end else begin
        want = expected_rsps.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 16'(got.status), 16'(want.status));
        if (got.result_pid !== want.result_pid)
          report_mismatch("result_pid", got.result_pid, want.result_pid);
        if (got.wait_status !== want.wait_status)
          report_mismatch("wait_status", got.wait_status, want.wait_status);
        if (got.queried_state !== want.queried_state)
          report_mismatch("queried_state", 16'(got.queried_state), 16'(want.queried_state));
        if (got.switched !== want.switched)
          report_mismatch("switched", 16'(got.switched), 16'(want.switched));
        if (got.running_slot !== want.running_slot)
          report_mismatch("running_slot", 16'(got.running_slot), 16'(want.running_slot));
        if (got.running_pid !== want.running_pid)
          report_mismatch("running_pid", got.running_pid, want.running_pid);
        if (want.switched) switches_seen++;
        if (want.wait_status != 0 || (want.result_pid != 0 && got.status == StOk &&
            want.queried_state == 0 && want.wait_status != 0)) reaps_seen++;
      end
      rsps_seen++;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (pending_reqs.size() == 0 && !s_axis_tvalid);
    wait (expected_rsps.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("%0d requests, %0d responses, %0d dispatch switches, %0d nonzero wait statuses",
             reqs_sent, rsps_seen, switches_seen, reaps_seen);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("** task_table_round_robin_scheduler: PASSED **");
    end else begin
      $display("** task_table_round_robin_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
